FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_sig, rst_n_sig, cond, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (cond)) \
		else $error(msg);

// Antecedent in this cycle requires consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk_sig, rst_n_sig, ante, cons, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/bcr_pkg.sv
package bcr_pkg;

	localparam int ROM_BANK_BITS_DEF = 7;
	localparam int MAP_W = 21;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_WRITE = 2'd0;
	localparam cmd_t CMD_READ  = 2'd1;
	localparam cmd_t CMD_TICK  = 2'd2;

	typedef logic [1:0] tgt_t;
	localparam tgt_t TGT_ROM  = 2'd0;
	localparam tgt_t TGT_RAM  = 2'd1;
	localparam tgt_t TGT_CLK  = 2'd2;
	localparam tgt_t TGT_NONE = 2'd3;

	// Address regions, by bits [15:13]
	localparam logic [2:0] REG_ROMBANK = 3'b001;
	localparam logic [2:0] REG_RAMSEL  = 3'b010;
	localparam logic [2:0] REG_LATCH   = 3'b011;
	localparam logic [2:0] REG_WINDOW  = 3'b101;

	localparam int NUM_CLK_REGS = 5;
	localparam logic [3:0] CLK_SEL_FIRST = 4'd8;
	localparam logic [3:0] CLK_SEL_LAST  = 4'd12;
	localparam logic [7:0] DAY_CARRY     = 8'h80;

	// Pending seconds held as d:h:m:s; saturation point is 0xffffffff seconds.
	localparam logic [15:0] SAT_DAYS  = 16'd49710;
	localparam logic [4:0]  SAT_HOURS = 5'd6;
	localparam logic [5:0]  SAT_MINS  = 6'd28;
	localparam logic [5:0]  SAT_SECS  = 6'd15;

	localparam logic [5:0] SEC_TOP  = 6'd59;
	localparam logic [4:0] HOUR_TOP = 5'd23;

endpackage

FILE: hw/rtl/bank_controller_with_rtc_core.sv
// A transaction taken into the input stage passes to the result register when that register is free.
// Throughput: one transaction per cycle while the result side is not stalled; state update and
// address mapping are done combinationally between the input stage and the result register.
// Reset (arst_n, async): ROM bank 1, RAM bank 0, RAM selected, latch low,
// clock registers and pending seconds cleared, both stages empty.
module bank_controller_with_rtc_core
	import bcr_pkg::*;
#(
	parameter int ROM_BANK_BITS = ROM_BANK_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           command,
	input  logic [15:0]          bus_address,
	input  logic [7:0]           write_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           target,
	output logic [MAP_W-1:0]     mapped_address,
	output logic [7:0]           clock_byte
);

	`include "assert_macros.svh"

	// input stage
	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	// state
	logic [ROM_BANK_BITS-1:0] rom_bank_q;
	logic [2:0]               ram_bank_q;
	logic [3:0]               clk_sel_q;
	logic                     latch_q;
	logic [7:0]               clk_regs_q [NUM_CLK_REGS];
	logic [5:0]               ps_q;
	logic [5:0]               pm_q;
	logic [4:0]               ph_q;
	logic [15:0]              pd_q;

	logic out_free;
	logic fire_s1;
	assign out_free = !out_valid || !out_stall;
	assign fire_s1  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= command;
			addr_s1 <= bus_address;
			data_s1 <= write_data;
		end
	end

	// decode
	logic [2:0] region;
	logic       is_write, is_read, is_tick, ctrl_area, window;
	logic       clk_mapped;
	logic [2:0] clk_idx;
	assign region     = addr_s1[15:13];
	assign is_write   = cmd_s1 == CMD_WRITE;
	assign is_read    = cmd_s1 == CMD_READ;
	assign is_tick    = cmd_s1 == CMD_TICK;
	assign ctrl_area  = !addr_s1[15];
	assign window     = region == REG_WINDOW;
	assign clk_mapped = clk_sel_q >= CLK_SEL_FIRST && clk_sel_q <= CLK_SEL_LAST;
	assign clk_idx    = clk_sel_q[2:0];

	// pending tick counter, saturating
	logic pend_sat, pend_zero;
	logic [5:0] ps_n, pm_n;
	logic [4:0] ph_n;
	logic [15:0] pd_n;
	assign pend_sat  = pd_q == SAT_DAYS && ph_q == SAT_HOURS && pm_q == SAT_MINS
		&& ps_q == SAT_SECS;
	assign pend_zero = pd_q == '0 && ph_q == '0 && pm_q == '0 && ps_q == '0;

	always_comb begin
		ps_n = ps_q;
		pm_n = pm_q;
		ph_n = ph_q;
		pd_n = pd_q;
		if (!pend_sat) begin
			ps_n = ps_q + 6'd1;
			if (ps_q == SEC_TOP) begin
				ps_n = '0;
				pm_n = pm_q + 6'd1;
				if (pm_q == SEC_TOP) begin
					pm_n = '0;
					ph_n = ph_q + 5'd1;
					if (ph_q == HOUR_TOP) begin
						ph_n = '0;
						pd_n = pd_q + 16'd1;
					end
				end
			end
		end
	end

	// latch fold: add pending d:h:m:s into the clock registers with carries
	logic [8:0]  sec_sum, min_sum, hr_sum;
	logic [7:0]  sec_f, min_f, hr_f;
	logic        c_sec, c_min, c_hr;
	logic [16:0] day_sum;
	logic [7:0]  dh_f;

	always_comb begin
		sec_sum = {1'b0, clk_regs_q[0]} + {3'b0, ps_q};
		c_sec   = sec_sum > 9'd59;
		sec_f   = c_sec ? 8'(sec_sum - 9'd60) : sec_sum[7:0];
		min_sum = {1'b0, clk_regs_q[1]} + {3'b0, pm_q} + {8'b0, c_sec};
		c_min   = min_sum > 9'd59;
		min_f   = c_min ? 8'(min_sum - 9'd60) : min_sum[7:0];
		hr_sum  = {1'b0, clk_regs_q[2]} + {4'b0, ph_q} + {8'b0, c_min};
		c_hr    = hr_sum > 9'd23;
		hr_f    = c_hr ? 8'(hr_sum - 9'd24) : hr_sum[7:0];
		day_sum = {8'b0, clk_regs_q[4][0], clk_regs_q[3]} + {1'b0, pd_q} + {16'b0, c_hr};
		dh_f    = {clk_regs_q[4][7:1], day_sum[8]};
		if (day_sum[16:9] != '0) begin
			dh_f = dh_f | DAY_CARRY;
		end
	end

	logic do_fold;
	assign do_fold = is_write && ctrl_area && region == REG_LATCH && !latch_q
		&& data_s1 == 8'd1 && !pend_zero;

	// result
	tgt_t             tgt_c;
	logic [MAP_W-1:0] map_c;
	logic [7:0]       cbyte_c;
	logic [7:0]       bank8;
	assign bank8 = 8'(rom_bank_q);

	always_comb begin
		tgt_c   = TGT_NONE;
		map_c   = '0;
		cbyte_c = '0;
		if (is_read && ctrl_area) begin
			tgt_c = TGT_ROM;
			map_c = addr_s1[14] ? {bank8[6:0], addr_s1[13:0]} : {5'b0, addr_s1};
		end else if ((is_read || is_write) && window) begin
			if (clk_sel_q == '0) begin
				tgt_c = TGT_RAM;
				map_c = MAP_W'({ram_bank_q, addr_s1[12:0]});
			end else if (clk_mapped) begin
				tgt_c = TGT_CLK;
				if (is_read) begin
					cbyte_c = clk_regs_q[clk_idx];
				end
			end
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q <= ROM_BANK_BITS'(1);
			ram_bank_q <= '0;
			clk_sel_q  <= '0;
			latch_q    <= 1'b0;
			for (int i = 0; i < NUM_CLK_REGS; i++) begin
				clk_regs_q[i] <= '0;
			end
			ps_q <= '0;
			pm_q <= '0;
			ph_q <= '0;
			pd_q <= '0;
		end else if (fire_s1) begin
			if (is_tick) begin
				ps_q <= ps_n;
				pm_q <= pm_n;
				ph_q <= ph_n;
				pd_q <= pd_n;
			end else if (is_write && ctrl_area) begin
				unique case (region)
					REG_LATCH: begin
						if (do_fold) begin
							clk_regs_q[0] <= sec_f;
							clk_regs_q[1] <= min_f;
							clk_regs_q[2] <= hr_f;
							clk_regs_q[3] <= day_sum[7:0];
							clk_regs_q[4] <= dh_f;
							ps_q <= '0;
							pm_q <= '0;
							ph_q <= '0;
							pd_q <= '0;
						end
						if (data_s1[7:1] == '0) begin
							latch_q <= data_s1[0];
						end
					end
					REG_RAMSEL: begin
						if (data_s1[7:3] != '0) begin
							clk_sel_q <= data_s1[3:0];
						end else begin
							clk_sel_q  <= '0;
							ram_bank_q <= data_s1[2:0];
						end
					end
					REG_ROMBANK: begin
						rom_bank_q <= (data_s1[ROM_BANK_BITS-1:0] == '0) ?
							ROM_BANK_BITS'(1) : data_s1[ROM_BANK_BITS-1:0];
					end
					default: begin
						// enable register area: ignored
					end
				endcase
			end else if (is_write && window && clk_sel_q != '0 && clk_mapped) begin
				clk_regs_q[clk_idx] <= data_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			target         <= tgt_c;
			mapped_address <= map_c;
			clock_byte     <= cbyte_c;
		end
	end

	`ASSERT_ALWAYS(a_rom_bank_nonzero, clk, arst_n, rom_bank_q != '0,
		"ROM bank register holds zero")
	`ASSERT_ALWAYS(a_pending_radix, clk, arst_n,
		ps_q <= SEC_TOP && pm_q <= SEC_TOP && ph_q <= HOUR_TOP,
		"pending seconds counter out of range")
	`ASSERT_ALWAYS(a_unmapped_zero, clk, arst_n,
		!out_valid || target == TGT_ROM || target == TGT_RAM || mapped_address == '0,
		"mapped address nonzero for clock or unmapped result")
	`ASSERT_ALWAYS(a_cbyte_clk_only, clk, arst_n,
		!out_valid || target == TGT_CLK || clock_byte == '0,
		"clock byte nonzero outside clock register access")
	`ASSERT_NEXT(a_fold_clears, clk, arst_n, fire_s1 && do_fold, pend_zero,
		"pending seconds not cleared by latch")

endmodule

FILE: bench/tb_bank_controller_with_rtc_core.sv
`timescale 1ns / 100ps

module tb_bank_controller_with_rtc_core;
	import bcr_pkg::*;

	localparam cmd_t CMD_NONE = 2'd3;
	localparam int RB_BITS = ROM_BANK_BITS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 40;
	localparam int RANDOM_PER_PHASE = 250;

	localparam logic [15:0] ADDR_ROMBANK = 16'h2000;
	localparam logic [15:0] ADDR_RAMSEL  = 16'h4000;
	localparam logic [15:0] ADDR_LATCH   = 16'h6000;
	localparam logic [15:0] ADDR_WINDOW  = 16'ha000;

	typedef struct {
		tgt_t             target;
		logic [MAP_W-1:0] mapped;
		logic [7:0]       cbyte;
	} bank_result_t;

	// Bank/clock predictor plus the queue of results still owed by the block.
	class bank_scoreboard;
		logic [RB_BITS-1:0] rom_bank;
		logic [2:0]         ram_bank;
		logic [3:0]         clk_sel;
		logic               latch_lvl;
		logic [7:0]         rtc[NUM_CLK_REGS];
		logic [31:0]        pending_secs;
		bank_result_t       expected_q[$];
		int unsigned        errors;

		function new();
			rom_bank = RB_BITS'(1);
			ram_bank = '0;
			clk_sel = '0;
			latch_lvl = 1'b0;
			foreach (rtc[i]) rtc[i] = '0;
			pending_secs = '0;
			errors = 0;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function void flag(string what, int unsigned exp_v, int unsigned act_v);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp_v, act_v);
		endfunction

		function void fold_pending();
			logic [31:0] d, sec, mins, hrs, days;
			logic carry;
			if (pending_secs == 0)
				return;
			d = pending_secs;
			sec = rtc[0] + d % 60;
			carry = 1'b0;
			if (sec > SEC_TOP) begin
				sec -= 60;
				carry = 1'b1;
			end
			d = d / 60;
			mins = rtc[1] + carry + d % 60;
			carry = 1'b0;
			if (mins > SEC_TOP) begin
				mins -= 60;
				carry = 1'b1;
			end
			d = d / 60;
			hrs = rtc[2] + carry + d % 24;
			carry = 1'b0;
			if (hrs > HOUR_TOP) begin
				hrs -= 24;
				carry = 1'b1;
			end
			d = d / 24;
			days = rtc[3] + {rtc[4][0], 8'h00} + carry + d;
			if (days > 511) begin
				days = days % 512;
				rtc[4] = rtc[4] | DAY_CARRY;
			end
			rtc[0] = sec[7:0];
			rtc[1] = mins[7:0];
			rtc[2] = hrs[7:0];
			rtc[3] = days[7:0];
			rtc[4] = {rtc[4][7:1], days[8]};
			pending_secs = '0;
		endfunction

		function void note_input(cmd_t cmd, logic [15:0] addr, logic [7:0] data);
			bank_result_t r;
			logic [2:0] region;
			logic [RB_BITS-1:0] bank_bits;
			int idx;
			region = addr[15:13];
			r.target = TGT_NONE;
			r.mapped = '0;
			r.cbyte = '0;
			if (cmd == CMD_TICK) begin
				if (pending_secs != '1)
					pending_secs++;
			end else if (cmd == CMD_WRITE && !addr[15]) begin
				if (region == REG_LATCH) begin
					if (!latch_lvl && data == 8'd1)
						fold_pending();
					if (data <= 8'd1)
						latch_lvl = data[0];
				end else if (region == REG_RAMSEL) begin
					if (data >= 8'd8) begin
						clk_sel = data[3:0];
					end else begin
						clk_sel = '0;
						ram_bank = data[2:0];
					end
				end else if (region == REG_ROMBANK) begin
					bank_bits = data[RB_BITS-1:0];
					rom_bank = (bank_bits == '0) ? RB_BITS'(1) : bank_bits;
				end
			end else if (cmd == CMD_READ && !addr[15]) begin
				r.target = TGT_ROM;
				if (!addr[14])
					r.mapped = MAP_W'(addr);
				else
					r.mapped = MAP_W'(rom_bank * 32'h4000 + addr[13:0]);
			end else if ((cmd == CMD_WRITE || cmd == CMD_READ) && region == REG_WINDOW) begin
				if (clk_sel == 0) begin
					r.target = TGT_RAM;
					r.mapped = MAP_W'(ram_bank * 32'h2000 + addr[12:0]);
				end else if (clk_sel >= CLK_SEL_FIRST && clk_sel <= CLK_SEL_LAST) begin
					idx = clk_sel - CLK_SEL_FIRST;
					r.target = TGT_CLK;
					if (cmd == CMD_WRITE)
						rtc[idx] = data;
					else
						r.cbyte = rtc[idx];
				end
			end
			expected_q.push_back(r);
		endfunction

		function void check_result(tgt_t tgt, logic [MAP_W-1:0] maddr, logic [7:0] cb);
			bank_result_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result with none expected: target %0h addr %0h byte %0h",
						$time, tgt, maddr, cb);
				return;
			end
			e = expected_q.pop_front();
			if (tgt !== e.target)
				flag("target", e.target, tgt);
			if (maddr !== e.mapped)
				flag("mapped_address", e.mapped, maddr);
			if (cb !== e.cbyte)
				flag("clock_byte", e.cbyte, cb);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [1:0]       command = CMD_NONE;
	logic [15:0]      bus_address = '0;
	logic [7:0]       write_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [1:0]       target;
	logic [MAP_W-1:0] mapped_address;
	logic [7:0]       clock_byte;

	bank_scoreboard sb = new();
	int unsigned cycles = 0;
	int unsigned n_sent = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;

	bank_controller_with_rtc_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.bus_address(bus_address),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.target(target),
		.mapped_address(mapped_address),
		.clock_byte(clock_byte)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_bank_controller_with_rtc_core: errors");
			$finish;
		end
	end

	// Result side: check on handshake, then pick the stall for the next cycle.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_result(target, mapped_address, clock_byte);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Offer one transaction and wait for it to be taken.
	task automatic send_txn(input cmd_t cmd, input logic [15:0] addr, input logic [7:0] data);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		bus_address <= addr;
		write_data <= data;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(cmd, addr, data);
		n_sent++;
	endtask

	task automatic select_clock(input int idx);
		send_txn(CMD_WRITE, ADDR_RAMSEL | 16'($urandom_range(16'h1fff)),
			8'(CLK_SEL_FIRST + idx));
	endtask

	function automatic logic [15:0] window_addr();
		return ADDR_WINDOW | 16'($urandom_range(16'h1fff));
	endfunction

	function automatic logic [7:0] clock_value();
		if ($urandom_range(1))
			return 8'($urandom_range(255));
		return 8'($urandom_range(20, 63));
	endfunction

	// One random chunk: a short well-formed sequence or a single loose transaction.
	task automatic random_chunk();
		int pick;
		int k;
		int idx;
		logic [7:0] d;
		pick = $urandom_range(99);
		if (pick < 15) begin
			// ticks, latch low-high, then read back every clock register
			k = ($urandom_range(9) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 40);
			repeat (k) send_txn(CMD_TICK, 16'($urandom), 8'($urandom));
			send_txn(CMD_WRITE, ADDR_LATCH | 16'($urandom_range(16'h1fff)), 8'd0);
			send_txn(CMD_WRITE, ADDR_LATCH | 16'($urandom_range(16'h1fff)), 8'd1);
			for (idx = 0; idx < NUM_CLK_REGS; idx++) begin
				select_clock(idx);
				send_txn(CMD_READ, window_addr(), 8'($urandom));
			end
		end else if (pick < 30) begin
			// preset a clock register and read it back
			idx = $urandom_range(NUM_CLK_REGS - 1);
			select_clock(idx);
			send_txn(CMD_WRITE, window_addr(), clock_value());
			send_txn(CMD_READ, window_addr(), 8'($urandom));
		end else if (pick < 40) begin
			send_txn(CMD_WRITE, ADDR_RAMSEL | 16'($urandom_range(16'h1fff)),
				8'($urandom_range(7)));
			repeat ($urandom_range(1, 4))
				send_txn(cmd_t'($urandom_range(1)), window_addr(), 8'($urandom));
		end else if (pick < 50) begin
			send_txn(CMD_WRITE, ADDR_ROMBANK | 16'($urandom_range(16'h1fff)), 8'($urandom));
			repeat ($urandom_range(1, 3))
				send_txn(CMD_READ, 16'($urandom_range(16'h7fff)), 8'($urandom));
		end else if (pick < 58) begin
			send_txn(CMD_READ, 16'($urandom_range(16'h7fff)), 8'($urandom));
		end else if (pick < 66) begin
			case ($urandom_range(3))
				0: d = 8'($urandom_range(7));
				1: d = 8'($urandom_range(CLK_SEL_FIRST, CLK_SEL_LAST));
				2: d = 8'($urandom_range(13, 15));
				default: d = 8'($urandom);
			endcase
			send_txn(CMD_WRITE, ADDR_RAMSEL | 16'($urandom_range(16'h1fff)), d);
		end else if (pick < 74) begin
			send_txn(cmd_t'($urandom_range(1)), window_addr(), clock_value());
		end else if (pick < 82) begin
			send_txn(CMD_TICK, 16'($urandom), 8'($urandom));
		end else if (pick < 88) begin
			d = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(1));
			send_txn(CMD_WRITE, ADDR_LATCH | 16'($urandom_range(16'h1fff)), d);
		end else begin
			send_txn(cmd_t'($urandom_range(3)), 16'($urandom), 8'($urandom));
		end
	endtask

	task automatic wait_drained();
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	initial begin
		int p;
		int phase_idle[4];
		int phase_stall[4];
		phase_idle = '{0, 51, 0, 19};
		phase_stall = '{0, 0, 51, 19};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: mapping extremes, bank masking, clock day counter at its top value, odd cases
		send_txn(CMD_READ, 16'h0000, 8'h00);
		send_txn(CMD_READ, 16'h4000, 8'hff);
		send_txn(CMD_READ, 16'h7fff, 8'h00);
		send_txn(CMD_WRITE, ADDR_ROMBANK, 8'h00);
		send_txn(CMD_READ, 16'h4000, 8'h00);
		send_txn(CMD_WRITE, 16'h3fff, 8'hff);
		send_txn(CMD_READ, 16'h7fff, 8'h00);
		send_txn(CMD_WRITE, ADDR_ROMBANK, 8'h80);
		send_txn(CMD_WRITE, 16'h0000, 8'h0a);
		send_txn(CMD_WRITE, ADDR_RAMSEL, 8'h07);
		send_txn(CMD_READ, ADDR_WINDOW, 8'h00);
		send_txn(CMD_WRITE, 16'hbfff, 8'h55);
		send_txn(CMD_WRITE, 16'h5fff, 8'(CLK_SEL_FIRST + 3));
		send_txn(CMD_WRITE, 16'ha123, 8'hff);
		send_txn(CMD_WRITE, ADDR_RAMSEL, 8'hf0 | 8'(CLK_SEL_LAST));
		send_txn(CMD_WRITE, 16'hbfff, 8'h01);
		send_txn(CMD_TICK, 16'hffff, 8'hff);
		send_txn(CMD_WRITE, ADDR_LATCH, 8'h00);
		send_txn(CMD_WRITE, 16'h7fff, 8'h01);
		send_txn(CMD_READ, ADDR_WINDOW, 8'h00);
		send_txn(CMD_WRITE, ADDR_LATCH, 8'h02);
		send_txn(CMD_WRITE, ADDR_RAMSEL, 8'h0d);
		send_txn(CMD_READ, 16'hb000, 8'h00);
		send_txn(CMD_READ, 16'h8000, 8'h00);
		send_txn(CMD_WRITE, 16'hffff, 8'hff);
		send_txn(CMD_NONE, 16'hffff, 8'hff);

		for (p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			// long receiver hold-off while the sender keeps pushing
			if (p == 2)
				hold_requests++;
			while (n_sent < 26 + (p + 1) * RANDOM_PER_PHASE)
				random_chunk();
			// sender pauses until the block has given back everything
			if (p == 1) begin
				in_valid <= 1'b0;
				wait_drained();
			end
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("tb_bank_controller_with_rtc_core: clean");
		else
			$display("tb_bank_controller_with_rtc_core: errors");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/bcr_pkg.sv
hw/rtl/bank_controller_with_rtc_core.sv
bench/tb_bank_controller_with_rtc_core.sv
